// File: hdl/piu2x_pkg.sv
package piu2x_pkg;

    typedef enum logic {
        OP_TABLE_LOAD = 1'b0,
        OP_PIXEL      = 1'b1
    } t_opcode;

    localparam int PIX_W      = 8;
    localparam int TIDX_W     = 16;
    localparam int OROW_W     = 11;
    localparam int OCOL_W     = 11;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = 4;
    localparam int FIFO_CW    = 5;
    localparam int MAX_RESULTS = 8;

    typedef struct packed {
        logic              last;
        logic [PIX_W-1:0]  value;
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
    } t_result;

endpackage

// File: hdl/palette_interpolating_upscaler_2x.sv
// 2x palette upscaler. Table-load beats (tuser[0] low) fill the 64K blend table, which must be
// loaded before pixels that use it. Pixel beats arrive row-major; end_of_row travels in
// tuser[1], end_of_frame in tlast. Each pixel yields 0, 2, 4 or 8 byte writes, each a
// (row, col, value) beat with tlast on the final beat of that pixel. The result write port
// moves one beat per cycle once a pixel starts, which waits for eight free queue slots. A
// table load or held first pixel writes nothing, others two or four beats on the first source
// row, four or eight on later rows (four in the usual mid-row case). An input register accepts
// the next beat while the engine works and a 16-entry output queue absorbs backpressure.
// The blend table and line store are synchronous memories; the line store is read and written
// back one slot behind, with the table read for the between-row blend one stage later.
module palette_interpolating_upscaler_2x
    import piu2x_pkg::*;
#(
    parameter int MAX_DOUBLED_WIDTH = 2048,
    parameter int MAX_SOURCE_ROWS   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // table_index[15:0], table_value[23:16], pixel[31:24]
    input  logic [31:0] i_s_axis_tdata,
    // opcode[0], end_of_row[1]
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_row[10:0], out_col[21:11], out_value[29:22], zero[31:30]
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    localparam int HALF   = MAX_DOUBLED_WIDTH / 2;
    localparam int CCW    = $clog2(HALF);
    localparam int CW     = CCW + 1;
    localparam int LDEPTH = 2 * HALF;
    localparam int RW     = $clog2(MAX_SOURCE_ROWS);

    // memories
    logic [PIX_W-1:0] r_blend_mem [0:(1<<TIDX_W)-1];
    logic [PIX_W-1:0] r_line_mem  [0:LDEPTH-1];
    logic [PIX_W-1:0] r_tq;
    logic [PIX_W-1:0] r_lq;

    // input register
    logic              r_in_vld;
    t_opcode           r_in_op;
    logic [TIDX_W-1:0] r_in_tidx;
    logic [PIX_W-1:0]  r_in_tval;
    logic [PIX_W-1:0]  r_in_pixel;
    logic              r_in_eor;
    logic              r_in_eof;

    // pixel state
    logic [PIX_W-1:0] r_held;
    logic [CCW-1:0]   r_col_cnt;
    logic [RW-1:0]    r_row_cnt;

    // engine
    logic             r_act;
    logic [2:0]       r_step;
    logic [2:0]       r_nres_m1;
    logic             r_cur_first;
    logic             r_cur_nd4;
    logic             r_cur_rnz;
    logic [CW-1:0]    r_cur_base;
    logic [RW-1:0]    r_cur_row;
    logic [PIX_W-1:0] r_cur_p;

    // line store / blend pipeline
    logic             r_s1_vld;
    logic             r_s1_rnz;
    logic [1:0]       r_s1_slot;
    logic [CW-1:0]    r_s1_col;
    logic [PIX_W-1:0] r_s1_val;
    logic             r_s2_vld;
    logic [1:0]       r_s2_slot;
    logic [PIX_W-1:0] r_bv [0:3];

    // output queue
    t_result              r_fifo [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0]   r_wp;
    logic [FIFO_AW-1:0]   r_rp;
    logic [FIFO_CW-1:0]   r_cnt;

    logic              start;
    logic              start_pix;
    logic              start_load;
    logic              st_clamp;
    logic [CCW-1:0]    st_c;
    logic              st_first;
    logic              st_eor;
    logic              st_nd4;
    logic              st_nd0;
    logic              st_rnz;
    logic [CW-1:0]     st_base;
    logic [2:0]        st_nres_m1;

    logic              cur_first;
    logic              cur_nd4;
    logic [CW-1:0]     cur_base;
    logic [RW-1:0]     cur_row;
    logic [PIX_W-1:0]  cur_p;
    logic [2:0]        cur_nres_m1;
    logic [2:0]        j;

    logic              push;
    logic              pop;
    logic              dbl;
    logic [1:0]        slot;
    logic [PIX_W-1:0]  val_dbl;
    logic [PIX_W-1:0]  val_btw;
    logic [RW:0]       row2;
    logic [RW:0]       rowb;
    logic [CW-1:0]     push_col;
    t_result           push_res;

    logic              t_rd_en;
    logic [TIDX_W-1:0] t_rd_addr;
    logic              l_rd_en;

    // ---------------- start decode ----------------
    assign start      = r_in_vld && !r_act && (r_cnt <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS));
    assign start_pix  = start && (r_in_op == OP_PIXEL);
    assign start_load = start && (r_in_op == OP_TABLE_LOAD);

    assign o_s_axis_tready = !r_in_vld || start;

    always_comb begin
        st_clamp = (r_col_cnt >= CCW'(HALF - 1));
        st_c     = st_clamp ? CCW'(HALF - 1) : r_col_cnt;
        st_first = (st_c == '0);
        st_eor   = r_in_eor || r_in_eof || st_clamp;
        st_nd4   = !st_first && st_eor;
        st_nd0   = st_first && !st_eor;
        st_rnz   = (r_row_cnt != '0);
        st_base  = st_first ? '0 : {CCW'(st_c - CCW'(1)), 1'b0};
        st_nres_m1 = {st_nd4 && st_rnz, st_nd4 || st_rnz, 1'b1};
    end

    always_comb begin
        if (start) begin
            cur_first   = st_first;
            cur_nd4     = st_nd4;
            cur_base    = st_base;
            cur_row     = r_row_cnt;
            cur_p       = r_in_pixel;
            cur_nres_m1 = st_nres_m1;
            j           = 3'd0;
        end else begin
            cur_first   = r_cur_first;
            cur_nd4     = r_cur_nd4;
            cur_base    = r_cur_base;
            cur_row     = r_cur_row;
            cur_p       = r_cur_p;
            cur_nres_m1 = r_nres_m1;
            j           = r_step;
        end
    end

    // ---------------- result generation ----------------
    always_comb begin
        push = (start_pix && !st_nd0) || r_act;
        dbl  = cur_nd4 ? !j[2] : (j[2:1] == 2'd0);
        if (dbl || cur_nd4) begin
            slot = j[1:0];
        end else begin
            slot = {1'b0, j[0]};
        end

        case ({cur_first, slot})
            3'b000:  val_dbl = r_held;
            3'b001:  val_dbl = r_tq;
            3'b010:  val_dbl = cur_p;
            3'b100:  val_dbl = cur_p;
            default: val_dbl = '0;
        endcase

        // take the blend straight from the table when it lands this cycle
        if (r_s2_vld && (r_s2_slot == slot)) begin
            val_btw = r_tq;
        end else begin
            val_btw = r_bv[slot];
        end

        row2     = {cur_row, 1'b0};
        rowb     = row2 - (RW+1)'(1);
        push_col = cur_base + CW'(slot);

        push_res.row   = dbl ? OROW_W'(row2) : OROW_W'(rowb);
        push_res.col   = OCOL_W'(push_col);
        push_res.value = dbl ? val_dbl : val_btw;
        push_res.last  = (j == cur_nres_m1);
    end

    // ---------------- memory port control ----------------
    assign l_rd_en   = push && dbl;
    assign t_rd_en   = start_pix || (r_s1_vld && r_s1_rnz);
    assign t_rd_addr = start_pix ? {r_in_pixel, r_held} : {r_s1_val, r_lq};

    always_ff @(posedge i_clk) begin
        if (start_load) begin
            r_blend_mem[r_in_tidx] <= r_in_tval;
        end
        if (t_rd_en) begin
            r_tq <= r_blend_mem[t_rd_addr];
        end
    end

    // read the line store one slot ahead of its write-back
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_line_mem[r_s1_col] <= r_s1_val;
        end
        if (l_rd_en) begin
            r_lq <= r_line_mem[push_col];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_held    <= '0;
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_act     <= 1'b0;
            r_step    <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end

            if (start_pix) begin
                if (st_eor) begin
                    r_col_cnt <= '0;
                    if (r_in_eof || (r_row_cnt >= RW'(MAX_SOURCE_ROWS - 1))) begin
                        r_row_cnt <= '0;
                    end else begin
                        r_row_cnt <= r_row_cnt + RW'(1);
                    end
                end else begin
                    r_held    <= r_in_pixel;
                    r_col_cnt <= st_c + CCW'(1);
                end
            end

            if (start_pix && !st_nd0) begin
                r_act  <= 1'b1;
                r_step <= 3'd1;
            end else if (r_act) begin
                r_step <= r_step + 3'd1;
                if (r_step == r_nres_m1) begin
                    r_act <= 1'b0;
                end
            end

            r_s1_vld <= push && dbl;
            r_s2_vld <= r_s1_vld && r_s1_rnz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op    <= t_opcode'(i_s_axis_tuser[0]);
            r_in_eor   <= i_s_axis_tuser[1];
            r_in_eof   <= i_s_axis_tlast;
            r_in_tidx  <= i_s_axis_tdata[15:0];
            r_in_tval  <= i_s_axis_tdata[23:16];
            r_in_pixel <= i_s_axis_tdata[31:24];
        end
        if (start_pix) begin
            r_cur_first <= st_first;
            r_cur_nd4   <= st_nd4;
            r_cur_rnz   <= st_rnz;
            r_cur_base  <= st_base;
            r_cur_row   <= r_row_cnt;
            r_cur_p     <= r_in_pixel;
            r_nres_m1   <= st_nres_m1;
        end
        if (push && dbl) begin
            r_s1_slot <= slot;
            r_s1_col  <= push_col;
            r_s1_val  <= val_dbl;
            r_s1_rnz  <= start ? st_rnz : r_cur_rnz;
        end
        if (r_s1_vld) begin
            r_s2_slot <= r_s1_slot;
        end
        if (r_s2_vld) begin
            r_bv[r_s2_slot] <= r_tq;
        end
    end

    // ---------------- output queue ----------------
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = {2'b00, r_fifo[r_rp].value, r_fifo[r_rp].col, r_fifo[r_rp].row};
    assign o_m_axis_tlast  = r_fifo[r_rp].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + FIFO_CW'(1);
                2'b01:   r_cnt <= r_cnt - FIFO_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= push_res;
        end
    end

    // ---------------- assertions ----------------
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt != FIFO_CW'(FIFO_DEPTH)) || pop)
        else $error("result queue overflow");

    a_table_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start_pix && r_s1_vld && r_s1_rnz))
        else $error("blend table read port claimed twice");

    a_line_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (l_rd_en && r_s1_vld) |-> (push_col != r_s1_col))
        else $error("line store read meets pending write-back");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_step <= r_nres_m1))
        else $error("engine step past result count");

    a_btw_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && !dbl) |-> !r_s1_vld || (r_s1_slot != slot) || !r_s1_rnz)
        else $error("between-row beat issued before its blend read");

endmodule

// File: tb/tb_palette_interpolating_upscaler_2x.sv
module tb_palette_interpolating_upscaler_2x;
    import piu2x_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_WIDTH  = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int PAL_SIZE    = 8;
    localparam int QUIET_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // table_index[15:0], table_value[23:16], pixel[31:24]
    logic [31:0] i_s_axis_tdata = '0;
    // opcode[0], end_of_row[1]
    logic [1:0]  i_s_axis_tuser = '0;
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // out_row[10:0], out_col[21:11], out_value[29:22], zero[31:30]
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    // predictor state
    logic [7:0]  blend_ref [65536];
    logic [7:0]  line_ref [2048];
    logic [7:0]  held_ref = '0;
    logic [10:0] col_ref = '0;
    logic [9:0]  row_ref = '0;
    int          line_extent = 0;

    t_result     expected_writes [$];
    logic [7:0]  palette [PAL_SIZE];
    int          mismatches = 0;
    int          beats_sent = 0;
    bit          steady = 1'b0;

    palette_interpolating_upscaler_2x u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= steady || ($urandom_range(0, 99) >= 22);
    end

    task automatic report_write(input string field, input int got, input int want_v);
        if (mismatches < 40)
            $display("mismatch at %0t ns: %s got %0d expected %0d", $realtime, field, got,
                     want_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_writes.size() == 0) begin
                report_write("unexpected write at row", int'(o_m_axis_tdata[10:0]), -1);
            end else begin
                want = expected_writes.pop_front();
                if (o_m_axis_tdata[10:0] != want.row)
                    report_write("row", int'(o_m_axis_tdata[10:0]), int'(want.row));
                if (o_m_axis_tdata[21:11] != want.col)
                    report_write("col", int'(o_m_axis_tdata[21:11]), int'(want.col));
                if (o_m_axis_tdata[29:22] != want.value)
                    report_write("value", int'(o_m_axis_tdata[29:22]), int'(want.value));
                if (o_m_axis_tlast != want.last)
                    report_write("last", int'(o_m_axis_tlast), int'(want.last));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // Expected writes for one accepted pixel: doubled row first, then between-row blends.
    task automatic upscale_predict(input logic [7:0] p, input logic eor_in, input logic eof);
        logic [10:0] cols [4];
        logic [7:0]  vals [4];
        logic [10:0] c;
        logic [9:0]  r;
        logic        eor;
        logic [7:0]  above;
        t_result     w;
        int          nd;
        nd = 0;
        eor = eor_in | eof;
        c = col_ref;
        r = row_ref;
        // the last line store slot closes the row
        if (c >= HALF_WIDTH - 1) begin
            c = 11'(HALF_WIDTH - 1);
            eor = 1'b1;
        end
        if (c > 0) begin
            cols[0] = 11'(2 * c - 2);
            vals[0] = held_ref;
            cols[1] = 11'(2 * c - 1);
            vals[1] = blend_ref[{p, held_ref}];
            nd = 2;
        end
        if (eor) begin
            cols[nd] = 11'(2 * c);
            vals[nd] = p;
            cols[nd + 1] = 11'(2 * c + 1);
            vals[nd + 1] = 8'h00;
            nd += 2;
            col_ref = '0;
            row_ref = (eof || r >= 10'(MAX_ROWS - 1)) ? '0 : r + 1'b1;
        end else begin
            held_ref = p;
            col_ref = c + 1'b1;
        end
        for (int i = 0; i < nd; i++) begin
            w.last = 1'b0;
            w.value = vals[i];
            w.col = cols[i];
            w.row = 11'(2 * r);
            expected_writes.push_back(w);
        end
        for (int i = 0; i < nd; i++) begin
            above = line_ref[cols[i]];
            if (r > 0) begin
                w.last = 1'b0;
                w.value = blend_ref[{vals[i], above}];
                w.col = cols[i];
                w.row = 11'(2 * r - 1);
                expected_writes.push_back(w);
            end
            line_ref[cols[i]] = vals[i];
            if (int'(cols[i]) + 1 > line_extent)
                line_extent = int'(cols[i]) + 1;
        end
        if (nd > 0)
            expected_writes[expected_writes.size() - 1].last = 1'b1;
    endtask

    task automatic send_beat(input logic [31:0] data, input logic [1:0] user, input logic tl);
        while (!steady && $urandom_range(0, 99) < 22) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= data;
        i_s_axis_tuser <= user;
        i_s_axis_tlast <= tl;
        do @(posedge i_clk); while (!o_s_axis_tready);
        beats_sent++;
    endtask

    task automatic send_load(input logic [15:0] idx, input logic [7:0] val);
        send_beat({8'($urandom), val, idx}, {1'($urandom), OP_TABLE_LOAD}, 1'($urandom));
        blend_ref[idx] = val;
    endtask

    task automatic send_pixel(input logic [7:0] p, input logic eor, input logic eof);
        send_beat({p, 8'($urandom), 16'($urandom)}, {eor, OP_PIXEL}, eof);
        upscale_predict(p, eor, eof);
    endtask

    function automatic logic [7:0] pick_color();
        return palette[$urandom_range(0, PAL_SIZE - 1)];
    endfunction

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge i_clk);
    endtask

    // Rows of random palette pixels, with stray table loads mixed in.
    task automatic send_row(input int n, input bit ends_frame);
        logic eof;
        logic eor;
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(0, 99) < 8) begin
                if ($urandom_range(0, 1) == 0)
                    send_load(16'($urandom), pick_color());
                else
                    send_load({pick_color(), pick_color()}, pick_color());
            end
            eof = (j == n - 1) && ends_frame;
            // end of frame alone must also close the row
            eor = (j == n - 1) && !(eof && $urandom_range(0, 3) == 0);
            send_pixel(pick_color(), eor, eof);
        end
    endtask

    // Every blend the pixels can reach stays inside the palette.
    task automatic test_table_fill();
        for (int a = 0; a < PAL_SIZE; a++)
            for (int b = 0; b < PAL_SIZE; b++)
                send_load({palette[b], palette[a]}, pick_color());
    endtask

    task automatic test_row_basics();
        send_pixel(8'hFF, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'hFF, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b1, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'hFF, 1'b0, 1'b0);
        send_load(16'hFFFF, palette[2]);
        send_pixel(8'hFF, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b1, 1'b0);
        send_pixel(8'hFF, 1'b1, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'hFF, 1'b0, 1'b1);
    endtask

    // No idling on either side through this stretch.
    task automatic test_long_row();
        steady = 1'b1;
        for (int j = 0; j < 48; j++)
            send_pixel(pick_color(), 1'b0, 1'b0);
        send_row(5, 1'b1);
        wait_drained();
        steady = 1'b0;
    endtask

    task automatic test_short_rows();
        for (int j = 0; j < 12; j++)
            send_pixel(pick_color(), 1'b1, 1'b0);
        send_row(3, 1'b0);
        send_row(2, 1'b1);
    endtask

    task automatic test_random_frames();
        int  target;
        int  rows;
        int  maxn;
        int  cap;
        bit  paused;
        target = beats_sent + 135;
        paused = 1'b0;
        while (beats_sent < target) begin
            rows = $urandom_range(1, 4);
            for (int k = 0; k < rows; k++) begin
                maxn = ($urandom_range(0, 19) == 0) ? 60 : 12;
                cap = (row_ref == 0 || line_extent / 2 > maxn) ? maxn : line_extent / 2;
                send_row($urandom_range(1, cap), k == rows - 1);
            end
            // hold off once until the output side has caught up
            if (!paused && beats_sent >= target - 70) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        palette[0] = 8'h00;
        palette[1] = 8'hFF;
        for (int i = 2; i < PAL_SIZE; i++)
            palette[i] = 8'($urandom);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_fill();
        test_row_basics();
        test_long_row();
        test_short_rows();
        test_random_frames();
        wait_drained();
        repeat (24) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
